### hw/rtl/aes_pkg.sv
package aes_pkg;

  localparam int NUM_RK = 60;
  localparam int RK_AW  = 6;

  // register indexes
  localparam logic [2:0] REG_KEY0 = 3'd0;
  localparam logic [2:0] REG_KEY1 = 3'd1;
  localparam logic [2:0] REG_KEY2 = 3'd2;
  localparam logic [2:0] REG_KEY3 = 3'd3;
  localparam logic [2:0] REG_IVH  = 3'd4;
  localparam logic [2:0] REG_IVL  = 3'd5;

  // queued job from front to back
  typedef struct packed {
    logic [127:0] ctr;
    logic [127:0] data;
    logic [4:0]   vb;
    logic         last;
  } job_t;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_KEY  = 2'd1,
    BK_RND  = 2'd2,
    BK_OUT  = 2'd3
  } bk_state_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return t[a];
  endfunction

  function automatic logic [7:0] xt(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sbox_word(input logic [31:0] w);
    return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction

  // byte i of the state sits at bits 127-8i
  function automatic logic [127:0] sub_shift(input logic [127:0] s);
    logic [127:0] o;
    o = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        o[127 - 8 * (r + 4 * c) -: 8] = sbox(s[127 - 8 * (r + 4 * ((c + r) % 4)) -: 8]);
      end
    end
    return o;
  endfunction

  function automatic logic [127:0] mix_cols(input logic [127:0] s);
    logic [127:0] o;
    logic [7:0] a, b, x, d;
    o = '0;
    for (int c = 0; c < 4; c++) begin
      a = s[127 - 32 * c -: 8];
      b = s[119 - 32 * c -: 8];
      x = s[111 - 32 * c -: 8];
      d = s[103 - 32 * c -: 8];
      o[127 - 32 * c -: 8] = xt(a) ^ xt(b) ^ b ^ x ^ d;
      o[119 - 32 * c -: 8] = a ^ xt(b) ^ xt(x) ^ x ^ d;
      o[111 - 32 * c -: 8] = a ^ b ^ xt(x) ^ xt(d) ^ d;
      o[103 - 32 * c -: 8] = xt(a) ^ a ^ b ^ x ^ xt(d);
    end
    return o;
  endfunction

endpackage

### hw/rtl/aes_front.sv
// Front: config registers, counter, and job queue toward the back
module aes_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_idx,
  input  logic [63:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [63:0]        in_block_hi,
  input  logic [63:0]        in_block_lo,
  input  logic [4:0]         in_valid_bytes,
  input  logic               in_last_block,
  output logic [255:0]       key,
  output logic               key_dirty,
  input  logic               key_taken,
  output logic               q_valid,
  input  logic               q_pop,
  output aes_pkg::job_t      q_job
);
  logic [63:0]  key_r [4];
  logic [127:0] iv_r, ctr_r;
  logic         dirty_r;
  // two-entry queue
  aes_pkg::job_t q_r [2];
  logic [1:0]   cnt_r;
  logic         rd_r, wr_r;
  logic         push;

  assign in_stall  = (cnt_r == 2'd2);
  assign push      = in_valid && !in_stall;
  assign q_valid   = (cnt_r != 2'd0);
  assign q_job     = q_r[rd_r];
  assign key       = {key_r[0], key_r[1], key_r[2], key_r[3]};
  assign key_dirty = dirty_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) key_r[i] <= '0;
      iv_r    <= '0;
      ctr_r   <= '0;
      dirty_r <= 1'b1;
      cnt_r   <= '0;
      rd_r    <= 1'b0;
      wr_r    <= 1'b0;
    end else begin
      if (key_taken) dirty_r <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_idx)
          aes_pkg::REG_KEY0: begin key_r[0] <= cfg_data; dirty_r <= 1'b1; end
          aes_pkg::REG_KEY1: begin key_r[1] <= cfg_data; dirty_r <= 1'b1; end
          aes_pkg::REG_KEY2: begin key_r[2] <= cfg_data; dirty_r <= 1'b1; end
          aes_pkg::REG_KEY3: begin key_r[3] <= cfg_data; dirty_r <= 1'b1; end
          aes_pkg::REG_IVH: begin
            iv_r[127:64]  <= cfg_data;
            ctr_r         <= {cfg_data, iv_r[63:0]};
          end
          aes_pkg::REG_IVL: begin
            iv_r[63:0]    <= cfg_data;
            ctr_r         <= {iv_r[127:64], cfg_data};
          end
          default: ;
        endcase
      end
      if (push) begin
        q_r[wr_r] <= '{ctr: ctr_r, data: {in_block_hi, in_block_lo},
                       vb: in_valid_bytes, last: in_last_block};
        wr_r      <= ~wr_r;
        ctr_r     <= in_last_block ? iv_r : ctr_r + 128'd1;
      end
      if (q_pop) rd_r <= ~rd_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end
endmodule

### hw/rtl/aes_back.sv
// Back: key expansion into round key RAM, round engine, output register
module aes_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [255:0]  key,
  input  logic          key_dirty,
  output logic          key_taken,
  input  logic          q_valid,
  output logic          q_pop,
  input  aes_pkg::job_t q_job,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [63:0]   out_out_hi,
  output logic [63:0]   out_out_lo,
  output logic [4:0]    out_out_valid_bytes,
  output logic          out_out_last
);
  aes_pkg::bk_state_t st_r, st_nxt;
  logic [127:0] rk_mem [aes_pkg::NUM_RK / 4];
  logic [127:0] rk_q;        // registered round key read
  logic [31:0]  w_r [8];     // sliding window of expansion
  logic [aes_pkg::RK_AW-1:0] ki_r;  // expansion word index
  logic [7:0]   rc_r;
  logic [3:0]   rnd_r;
  logic [127:0] s_r;
  aes_pkg::job_t job_r;
  logic [127:0] ks, masked;
  logic [31:0]  t, nw;
  logic         ovalid_r;
  logic         rd_phase_r;

  // expansion word
  always_comb begin
    t = w_r[7];
    if (ki_r[2:0] == 3'd0)
      t = aes_pkg::sbox_word({w_r[7][23:0], w_r[7][31:24]}) ^ {rc_r, 24'h0};
    else if (ki_r[2:0] == 3'd4)
      t = aes_pkg::sbox_word(w_r[7]);
    nw = w_r[0] ^ t;
  end

  // key words are written one per cycle into 128-bit round key rows;
  // each round reads its own row
  always_ff @(posedge clk) begin
    if (st_r == aes_pkg::BK_KEY)
      rk_mem[ki_r[5:2]][127 - 32 * ki_r[1:0] -: 32] <=
        (ki_r < 6'd8) ? key[255 - 32 * ki_r -: 32] : nw;
    rk_q <= rk_mem[rnd_r];
  end

  always_comb begin
    ks = s_r ^ rk_q;
    masked = '0;
    for (int i = 0; i < 16; i++)
      if (5'(i) < job_r.vb) masked[127 - 8 * i -: 8] = job_r.data[127 - 8 * i -: 8] ^ ks[127 - 8 * i -: 8];
  end

  always_comb begin
    st_nxt    = st_r;
    q_pop     = 1'b0;
    key_taken = 1'b0;
    unique case (st_r)
      aes_pkg::BK_IDLE:
        if (q_valid && !(ovalid_r && out_stall)) begin
          if (key_dirty) begin
            st_nxt = aes_pkg::BK_KEY;
            key_taken = 1'b1;
          end else begin
            st_nxt = aes_pkg::BK_RND;
            q_pop  = 1'b1;
          end
        end
      aes_pkg::BK_KEY:
        if (ki_r == 6'(aes_pkg::NUM_RK - 1)) st_nxt = aes_pkg::BK_IDLE;
      aes_pkg::BK_RND:
        if (rnd_r == 4'd14 && rd_phase_r) st_nxt = aes_pkg::BK_OUT;
      aes_pkg::BK_OUT:
        st_nxt = aes_pkg::BK_IDLE;
      default: st_nxt = aes_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= aes_pkg::BK_IDLE;
      ovalid_r <= 1'b0;
      ki_r     <= '0;
      rnd_r    <= '0;
      rd_phase_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (ovalid_r && !out_stall) ovalid_r <= 1'b0;
      unique case (st_r)
        aes_pkg::BK_IDLE: begin
          ki_r  <= '0;
          rc_r  <= 8'h01;
          rnd_r <= '0;
          rd_phase_r <= 1'b0;
          if (q_pop) begin
            job_r <= q_job;
            s_r   <= q_job.ctr;
          end
        end
        aes_pkg::BK_KEY: begin
          ki_r <= ki_r + 6'd1;
          for (int i = 0; i < 7; i++) w_r[i] <= w_r[i + 1];
          w_r[7] <= (ki_r < 6'd8) ? key[255 - 32 * ki_r -: 32] : nw;
          if (ki_r >= 6'd8 && ki_r[2:0] == 3'd0) rc_r <= aes_pkg::xt(rc_r);
        end
        aes_pkg::BK_RND: begin
          // a phase to read the round key, then a phase to apply the round;
          // the last key is added on the way out
          rd_phase_r <= ~rd_phase_r;
          if (rd_phase_r && rnd_r != 4'd14) begin
            rnd_r <= rnd_r + 4'd1;
            if (rnd_r == 4'd13) s_r <= aes_pkg::sub_shift(ks);
            else s_r <= aes_pkg::mix_cols(aes_pkg::sub_shift(ks));
          end
        end
        aes_pkg::BK_OUT: begin
          ovalid_r            <= 1'b1;
          out_out_hi          <= masked[127:64];
          out_out_lo          <= masked[63:0];
          out_out_valid_bytes <= job_r.vb;
          out_out_last        <= job_r.last;
        end
        default: ;
      endcase
    end
  end

  assign out_valid = ovalid_r;
endmodule

### hw/rtl/aes256_ctr_block_cipher.sv
// AES-256-CTR block cipher.
// Input channel in_*: one 16-byte data block per beat (valid/stall).
// Output channel out_*: one result beat per input beat, in order.
// cfg_*: write-only registers: key words 0..3 at index 0..3, iv high/low
// at index 4/5. Writing an IV register reloads the counter.
// With the engine free, an input beat is taken from the queue, then for each
// of fifteen round keys a round key read is followed by the round, and the
// output is loaded; after a key write or reset, key expansion runs before
// the first block.
// The single round unit and its round key read work on one block at a time:
// the next block is taken from the queue only after the last result is loaded.
// A two-beat queue sits between input and the round engine, so inputs are
// accepted while the engine runs or a result waits, until the queue is full.
// Reset clears the counter, keys and IV to zero and forces expansion.
// While out_stall is high the result holds and the engine waits.
module aes256_ctr_block_cipher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_block_hi,
  input  logic [63:0] in_block_lo,
  input  logic [4:0]  in_valid_bytes,
  input  logic        in_last_block,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_out_hi,
  output logic [63:0] out_out_lo,
  output logic [4:0]  out_out_valid_bytes,
  output logic        out_out_last
);
  logic [255:0]  key;
  logic          key_dirty, key_taken, q_valid, q_pop;
  aes_pkg::job_t q_job;

  aes_front u_front (
    .clk, .rst_n, .cfg_we, .cfg_idx, .cfg_data,
    .in_valid, .in_stall, .in_block_hi, .in_block_lo, .in_valid_bytes, .in_last_block,
    .key, .key_dirty, .key_taken, .q_valid, .q_pop, .q_job
  );

  aes_back u_back (
    .clk, .rst_n, .key, .key_dirty, .key_taken, .q_valid, .q_pop, .q_job,
    .out_valid, .out_stall, .out_out_hi, .out_out_lo, .out_out_valid_bytes, .out_out_last
  );
endmodule

### hw/rtl/aes_checker.sv
module aes_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [4:0]  out_out_valid_bytes,
  input logic [63:0] out_out_lo
);
  // stalled result beat stays valid and its low word holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_out_lo)) else $error("out hold");
  // no result right after reset
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid) else $error("out after reset");
  // input open right after reset
  a_rdy: assert property (@(posedge clk) !rst_n |=> !in_stall) else $error("stall after reset");
  // results never come back to back
  a_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall |=> !out_valid) else $error("back to back result");
  // a zero byte count gives a zero low data word
  a_vb: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_out_valid_bytes != 5'd0 || out_out_lo == 64'd0) else $error("mask");
endmodule

bind aes256_ctr_block_cipher aes_checker u_chk (
  .clk, .rst_n, .in_stall, .out_valid, .out_stall,
  .out_out_valid_bytes, .out_out_lo
);
